@@ rtl/bs77_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the 7x7 box sum stream unit
// no dependencies

package bs77_pkg;

   typedef logic [15:0] pixel_type;
   typedef logic [15:0] sum_type;
   typedef logic [12:0] coord_type;
   typedef logic [13:0] reg_type;
   typedef logic [7:0]  csr_index_type;

   // register indexes
   localparam csr_index_type CSR_ROW_WIDTH  = 8'd0;
   localparam csr_index_type CSR_IMAGE_ROWS = 8'd1;

   localparam reg_type ROW_WIDTH_RESET  = 14'd4144;
   localparam reg_type IMAGE_ROWS_RESET = 14'd4362;
   localparam int unsigned ROW_LIMIT    = 8192;

   // effective frame geometry and restart strobe
   typedef struct packed {
      reg_type width;
      reg_type rows;
      logic    restart;
   } cfg_type;

   // per-item control from the row front end to the accumulate stage
   typedef struct packed {
      logic      update;
      logic      emit;
      logic      use_prev;
      logic      use_old;
      sum_type   hsum;
      coord_type out_row;
      coord_type out_column;
   } front_type;

endpackage

@@ rtl/bs77_req_if.sv @@
`timescale 1ns / 1ps
// pixel input channel: valid, ready and one pixel
// depends on bs77_pkg

interface bs77_req_if;
   logic                valid;
   logic                ready;
   bs77_pkg::pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

@@ rtl/bs77_rsp_if.sv @@
`timescale 1ns / 1ps
// result channel: valid, ready, window sum and centre coordinates
// depends on bs77_pkg

interface bs77_rsp_if;
   logic                valid;
   logic                ready;
   bs77_pkg::sum_type   window_sum;
   bs77_pkg::coord_type out_row;
   bs77_pkg::coord_type out_column;

   modport source (output valid, output window_sum, output out_row, output out_column,
                   input ready);
   modport sink   (input valid, input window_sum, input out_row, input out_column,
                   output ready);
endinterface

@@ rtl/bs77_csr_if.sv @@
`timescale 1ns / 1ps
// register write channel: valid, ready, index and data
// depends on bs77_pkg

interface bs77_csr_if;
   logic                    valid;
   logic                    ready;
   bs77_pkg::csr_index_type index;
   bs77_pkg::reg_type       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/bs77_csr_regs.sv @@
`timescale 1ns / 1ps
// configuration registers, clamped frame geometry and restart strobe
// depends on bs77_pkg

module bs77_csr_regs #(
   parameter int unsigned MAX_ROW_PIXELS = 8192
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_valid,
   input  bs77_pkg::csr_index_type wr_index,
   input  bs77_pkg::reg_type       wr_data,
   output bs77_pkg::cfg_type       cfg
);
   import bs77_pkg::*;

   reg_type row_width_ff, row_width_in;
   reg_type image_rows_ff, image_rows_in;
   logic    restart;

   always_comb begin
      row_width_in  = row_width_ff;
      image_rows_in = image_rows_ff;
      restart       = 1'b0;
      if (wr_valid) begin
         unique case (wr_index)
            CSR_ROW_WIDTH: begin
               row_width_in = wr_data;
               restart      = 1'b1;
            end
            CSR_IMAGE_ROWS: begin
               image_rows_in = wr_data;
               restart       = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= ROW_WIDTH_RESET;
         image_rows_ff <= IMAGE_ROWS_RESET;
      end else begin
         row_width_ff  <= row_width_in;
         image_rows_ff <= image_rows_in;
      end
   end

   // zero behaves as one, oversize clamps
   always_comb begin
      if (row_width_ff == '0)
         cfg.width = 14'd1;
      else if (32'(row_width_ff) > MAX_ROW_PIXELS)
         cfg.width = 14'(MAX_ROW_PIXELS);
      else
         cfg.width = row_width_ff;
      if (image_rows_ff == '0)
         cfg.rows = 14'd1;
      else if (32'(image_rows_ff) > ROW_LIMIT)
         cfg.rows = 14'(ROW_LIMIT);
      else
         cfg.rows = image_rows_ff;
      cfg.restart = restart;
   end

endmodule

@@ rtl/bs77_row_front.sv @@
`timescale 1ns / 1ps
// row front end: pixel window, running horizontal sum, counters, ring addresses
// depends on bs77_pkg

module bs77_row_front #(
   parameter int unsigned MAX_ROW_PIXELS = 8192,
   parameter int unsigned HALF_WIDTH     = 3,
   parameter int unsigned HALF_HEIGHT    = 3,
   parameter int unsigned EDGE_BLOCK     = 16,
   localparam int unsigned RING_ROWS     = 2 * HALF_HEIGHT + 1,
   localparam int unsigned ADDR_W        = $clog2(RING_ROWS * MAX_ROW_PIXELS)
) (
   input  logic                clock,
   input  logic                reset,
   input  bs77_pkg::cfg_type   cfg,
   input  logic                accept,
   input  bs77_pkg::pixel_type pixel,
   output bs77_pkg::front_type info,
   output logic [ADDR_W-1:0]   slot_addr,
   output logic [ADDR_W-1:0]   prev_addr
);
   import bs77_pkg::*;

   localparam int unsigned WIN_LEN = 2 * HALF_WIDTH + 1;
   localparam int unsigned COL_W   = $clog2(MAX_ROW_PIXELS);
   localparam int unsigned SLOT_W  = $clog2(RING_ROWS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_ROWS - 1);

   logic [COL_W-1:0]  col_ff, col_in;
   coord_type         row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] pslot_ff, pslot_in;
   pixel_type         window_ff [WIN_LEN];
   sum_type           hsum_ff;
   sum_type           hsum_in;

   logic [31:0] col_x;
   logic        row_end;
   logic        frame_end;

   assign col_x     = 32'(col_ff) - HALF_WIDTH;
   assign row_end   = (32'(col_ff) + 32'd1) >= 32'(cfg.width);
   assign frame_end = (32'(row_ff) + 32'd1) >= 32'(cfg.rows);

   // new horizontal sum: add the new pixel, drop the oldest one; at column zero it restarts from the pixel
   assign hsum_in = (col_ff == '0) ? pixel : sum_type'(hsum_ff + pixel - window_ff[WIN_LEN-1]);

   always_comb begin
      info.update     = (32'(col_ff) >= HALF_WIDTH) && ((col_x + EDGE_BLOCK) < 32'(cfg.width));
      info.emit       = info.update && (32'(row_ff) >= HALF_HEIGHT);
      info.use_prev   = (row_ff != '0);
      info.use_old    = (32'(row_ff) >= RING_ROWS);
      info.hsum       = hsum_in;
      info.out_row    = coord_type'(row_ff - coord_type'(HALF_HEIGHT));
      info.out_column = coord_type'(col_x);
      slot_addr = ADDR_W'(slot_ff) * ADDR_W'(MAX_ROW_PIXELS) + ADDR_W'(col_x);
      prev_addr = ADDR_W'(pslot_ff) * ADDR_W'(MAX_ROW_PIXELS) + ADDR_W'(col_x);
   end

   always_comb begin
      col_in   = COL_W'(col_ff + 1'b1);
      row_in   = row_ff;
      slot_in  = slot_ff;
      pslot_in = pslot_ff;
      if (row_end) begin
         col_in = '0;
         if (frame_end) begin
            row_in   = '0;
            slot_in  = '0;
            pslot_in = LAST_SLOT;
         end else begin
            row_in   = coord_type'(row_ff + 1'b1);
            slot_in  = (slot_ff == LAST_SLOT) ? '0 : SLOT_W'(slot_ff + 1'b1);
            pslot_in = slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         col_ff   <= '0;
         row_ff   <= '0;
         slot_ff  <= '0;
         pslot_ff <= LAST_SLOT;
      end else if (accept) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         slot_ff  <= slot_in;
         pslot_ff <= pslot_in;
      end
   end

   // window restarts at column zero, so no reset is needed
   always_ff @(posedge clock) begin
      if (accept) begin
         hsum_ff      <= hsum_in;
         window_ff[0] <= pixel;
         for (int i = 1; i < WIN_LEN; i++)
            window_ff[i] <= (col_ff == '0) ? '0 : window_ff[i-1];
      end
   end

endmodule

@@ rtl/bs77_col_mem.sv @@
`timescale 1ns / 1ps
// column total ring memory: one write port, two registered read ports
// depends on bs77_pkg

module bs77_col_mem #(
   parameter int unsigned DEPTH  = 57344,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output bs77_pkg::sum_type rd_data_a,
   output bs77_pkg::sum_type rd_data_b,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  bs77_pkg::sum_type wr_data
);
   import bs77_pkg::*;

   sum_type totals_ff [DEPTH];
   sum_type rd_a_ff;
   sum_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         totals_ff[wr_addr] <= wr_data;
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= totals_ff[rd_addr_a];
         rd_b_ff <= totals_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

   // a write never lands on an entry read in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr_a) && (wr_addr != rd_addr_b))
      else $error("column memory read and write hit the same entry");

endmodule

@@ rtl/box_sum_7x7_stream_unit.sv @@
`timescale 1ns / 1ps
// top level of the streaming 7x7 box sum: channels, accumulate stage, result register
// depends on bs77_pkg, the channel interfaces, bs77_csr_regs, bs77_row_front, bs77_col_mem

// channel   dir  modport  payload
// req_if    in   sink     pixel (16)
// rsp_if    out  source   window_sum (16), out_row (13), out_column (13)
// csr_if    in   sink     index (8), data (14); always ready
//
// one pixel per cycle sustained while no held result stalls the accumulate stage
// the pipe is front end, memory read into the accumulate stage, then the result register
// reset is synchronous; no clearing pass, unwritten ring slots are never used
// a held result stalls the accumulate stage when it holds an emitting item; req ready then drops

module box_sum_7x7_stream_unit #(
   parameter int unsigned MAX_ROW_PIXELS = 8192,
   parameter int unsigned HALF_WIDTH     = 3,
   parameter int unsigned HALF_HEIGHT    = 3,
   parameter int unsigned EDGE_BLOCK     = 16
) (
   input  logic       clock,
   input  logic       reset,
   bs77_req_if.sink   req_if,
   bs77_rsp_if.source rsp_if,
   bs77_csr_if.sink   csr_if
);
   import bs77_pkg::*;

   localparam int unsigned RING_ROWS = 2 * HALF_HEIGHT + 1;
   localparam int unsigned DEPTH     = RING_ROWS * MAX_ROW_PIXELS;
   localparam int unsigned ADDR_W    = $clog2(DEPTH);

   cfg_type           cfg;
   front_type         info;
   logic [ADDR_W-1:0] slot_addr;
   logic [ADDR_W-1:0] prev_addr;
   logic              req_accept;

   // accumulate stage
   logic              s1_valid_ff, s1_valid_in;
   front_type         s1_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_free;
   sum_type           rd_old;
   sum_type           rd_prev;
   sum_type           total;
   sum_type           window;
   logic              mem_we;

   // result register
   logic      out_valid_ff, out_valid_in;
   sum_type   out_sum_ff;
   coord_type out_row_ff;
   coord_type out_col_ff;

   assign csr_if.ready = 1'b1;

   bs77_csr_regs #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   assign req_accept = req_if.valid && req_if.ready;

   bs77_row_front #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
      .HALF_WIDTH     (HALF_WIDTH),
      .HALF_HEIGHT    (HALF_HEIGHT),
      .EDGE_BLOCK     (EDGE_BLOCK)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (req_accept),
      .pixel     (req_if.pixel),
      .info      (info),
      .slot_addr (slot_addr),
      .prev_addr (prev_addr)
   );

   // same-entry read and write are a full row of transactions apart, so the
   // read-modify-write through the accumulate stage needs no forwarding
   bs77_col_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept && info.update),
      .rd_addr_a (slot_addr),
      .rd_addr_b (prev_addr),
      .rd_data_a (rd_old),
      .rd_data_b (rd_prev),
      .wr_en     (mem_we),
      .wr_addr   (s1_addr_ff),
      .wr_data   (total)
   );

   // stage moves on unless its result would hit a full, stalled result register
   assign s1_free      = !s1_valid_ff || !s1_ff.emit || !out_valid_ff || rsp_if.ready;
   assign req_if.ready = s1_free;

   // new column total and the difference against seven rows back
   assign total  = sum_type'(s1_ff.hsum + (s1_ff.use_prev ? rd_prev : '0));
   assign window = sum_type'(total - (s1_ff.use_old ? rd_old : '0));
   assign mem_we = s1_valid_ff && s1_free;

   // only items that touch the ring enter the stage
   always_comb begin
      if (req_accept)
         s1_valid_in = info.update;
      else if (s1_free)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
   end

   always_comb begin
      if (s1_valid_ff && s1_free && s1_ff.emit)
         out_valid_in = 1'b1;
      else if (rsp_if.ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff      <= info;
         s1_addr_ff <= slot_addr;
      end
      if (s1_valid_ff && s1_free && s1_ff.emit) begin
         out_sum_ff <= window;
         out_row_ff <= s1_ff.out_row;
         out_col_ff <= s1_ff.out_column;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.window_sum = out_sum_ff;
   assign rsp_if.out_row    = out_row_ff;
   assign rsp_if.out_column = out_col_ff;

   // a stalled stage keeps its memory read data
   a_hold_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_free) |=> ($stable(rd_old) && $stable(rd_prev)))
      else $error("read data changed under a stalled accumulate stage");

   // an emitting pixel reaches the accumulate stage
   a_emit_enters: assert property (@(posedge clock) disable iff (reset)
      (req_accept && info.emit) |=> (s1_valid_ff && s1_ff.emit))
      else $error("emitting transaction lost before the accumulate stage");

   // a result leaving the stage lands in the result register with its column unchanged
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_free && s1_ff.emit) |=>
         (out_valid_ff && (out_col_ff == $past(s1_ff.out_column))))
      else $error("result register not loaded from the accumulate stage");

endmodule
